FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: sv/dddu_pkg.sv
// ----------------------------------------------------------------------------
// dddu_pkg
// Widths, constants and types of the date difference unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dddu_pkg;

    localparam int YEAR_W  = 14;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;
    localparam int DN_W    = 23;   // day number, unsigned
    localparam int DIFF_W  = 23;   // result, signed
    localparam int WIDE_W  = DN_W + 1;

    localparam int YEAR_MAX_DEF = 9999;

    localparam logic signed [WIDE_W-1:0] DIFF_MAX = WIDE_W'(4194303);
    localparam logic signed [WIDE_W-1:0] DIFF_MIN = -WIDE_W'(4194304);

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
    } date_t;

    typedef struct packed {
        logic [DN_W-1:0] dn;
        logic            ok;
    } lane_out_t;

    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

endpackage

`default_nettype wire

FILE: sv/dddu_lane.sv
// ----------------------------------------------------------------------------
// dddu_lane
// One date: two-stage day number and legality check.
// ----------------------------------------------------------------------------
`default_nettype none

module dddu_lane #(
    parameter int YEAR_MAX = dddu_pkg::YEAR_MAX_DEF
) (
    input  wire                  clk,
    input  dddu_pkg::stage_en_t  en,
    input  dddu_pkg::date_t      date,
    output dddu_pkg::lane_out_t  result
);

    localparam int YW       = dddu_pkg::YEAR_W;
    localparam int Q4_W     = YW - 2;
    localparam int Q100_W   = 8;
    localparam int RECIP_W  = 13;
    localparam int RECIP    = 5243;   // ~2^17 / 25
    localparam int RECIP_SH = 17;

    localparam logic [dddu_pkg::MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [dddu_pkg::MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [dddu_pkg::MON_W-1:0] MON_DEC = 4'd12;

    // y / 100 = (y / 4) / 25, reciprocal multiply exact for 12-bit quotients
    function automatic logic [Q100_W-1:0] div100(input logic [YW-1:0] y);
        logic [Q4_W+RECIP_W-1:0] p;
        begin
            p = (Q4_W+RECIP_W)'(y[YW-1:2]) * (Q4_W+RECIP_W)'(RECIP);
            return p[RECIP_SH +: Q100_W];
        end
    endfunction

    function automatic logic is_leap(input logic [YW-1:0] y, input logic [Q100_W-1:0] q);
        logic cent;
        begin
            cent = (y == YW'(YW'(q) * YW'(100)));
            return cent ? (q[1:0] == 2'd0) : (y[1:0] == 2'd0);
        end
    endfunction

    function automatic logic [8:0] days_before(input logic [dddu_pkg::MON_W-1:0] m);
        begin
            case (m)
                4'd0:    return 9'd0;
                4'd1:    return 9'd0;
                4'd2:    return 9'd31;
                4'd3:    return 9'd59;
                4'd4:    return 9'd90;
                4'd5:    return 9'd120;
                4'd6:    return 9'd151;
                4'd7:    return 9'd181;
                4'd8:    return 9'd212;
                4'd9:    return 9'd243;
                4'd10:   return 9'd273;
                4'd11:   return 9'd304;
                4'd12:   return 9'd334;
                default: return 9'd365;
            endcase
        end
    endfunction

    function automatic logic [dddu_pkg::DAY_W-1:0] month_len(
        input logic [dddu_pkg::MON_W-1:0] m,
        input logic                       leap
    );
        begin
            case (m)
                4'd2:    return leap ? 5'd29 : 5'd28;
                4'd4,
                4'd6,
                4'd9,
                4'd11:   return 5'd30;
                4'd1,
                4'd3,
                4'd5,
                4'd7,
                4'd8,
                4'd10,
                4'd12:   return 5'd31;
                default: return 5'd0;
            endcase
        end
    endfunction

    // stage 1
    logic [YW-1:0]                  ysat;
    logic [YW-1:0]                  nyr;
    logic [dddu_pkg::DN_W-1:0]      y365_reg;
    logic [Q4_W-1:0]                nq4_reg;
    logic [Q100_W-1:0]              nq100_reg;
    logic [YW-1:0]                  ysat_reg;
    logic [Q100_W-1:0]              sq100_reg;
    logic [YW-1:0]                  yraw_reg;
    logic [Q100_W-1:0]              rq100_reg;
    logic                           yzero_reg;
    logic [dddu_pkg::MON_W-1:0]     mon_reg;
    logic [dddu_pkg::DAY_W-1:0]     day_reg;

    assign ysat = (int'(date.year) > YEAR_MAX) ? YW'(YEAR_MAX) : date.year;
    assign nyr  = ysat - YW'(1);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            y365_reg  <= dddu_pkg::DN_W'(ysat) * dddu_pkg::DN_W'(365);
            nq4_reg   <= nyr[YW-1:2];
            nq100_reg <= div100(nyr);
            ysat_reg  <= ysat;
            sq100_reg <= div100(ysat);
            yraw_reg  <= date.year;
            rq100_reg <= div100(date.year);
            yzero_reg <= (ysat == '0);
            mon_reg   <= date.month;
            day_reg   <= date.day;
        end
    end

    // stage 2
    logic                       leap_sat;
    logic                       leap_raw;
    logic [Q4_W-1:0]            leaps;
    logic [dddu_pkg::DN_W-1:0]  dn_next;
    logic                       ok_next;
    logic [dddu_pkg::DN_W-1:0]  dn_reg;
    logic                       ok_reg;

    always_comb
    begin
        leap_sat = is_leap(ysat_reg, sq100_reg);
        leap_raw = is_leap(yraw_reg, rq100_reg);
        // leap years in 0 .. y-1, year 0 included
        leaps = yzero_reg ? '0
              : nq4_reg - Q4_W'(nq100_reg) + Q4_W'(nq100_reg[Q100_W-1:2]) + Q4_W'(1);
        dn_next = y365_reg + dddu_pkg::DN_W'(leaps)
                + dddu_pkg::DN_W'(days_before(mon_reg))
                + dddu_pkg::DN_W'(day_reg)
                + dddu_pkg::DN_W'(leap_sat && (mon_reg > MON_FEB));
        ok_next = (mon_reg >= MON_JAN) && (mon_reg <= MON_DEC) && (day_reg != '0)
               && (day_reg <= month_len(mon_reg, leap_raw));
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            dn_reg <= dn_next;
            ok_reg <= ok_next;
        end
    end

    assign result.dn = dn_reg;
    assign result.ok = ok_reg;

endmodule

`default_nettype wire

FILE: sv/dddu_merge.sv
// ----------------------------------------------------------------------------
// dddu_merge
// Subtracts the two lane day numbers, saturates to the result width and registers the legality flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dddu_merge (
    input  wire                               clk,
    input  wire                               en,
    input  dddu_pkg::lane_out_t               lane_a,
    input  dddu_pkg::lane_out_t               lane_b,
    output logic signed [dddu_pkg::DIFF_W-1:0] diff,
    output logic                              first_valid,
    output logic                              second_valid
);

    logic signed [dddu_pkg::WIDE_W-1:0] wide;
    logic signed [dddu_pkg::DIFF_W-1:0] diff_next;
    logic signed [dddu_pkg::DIFF_W-1:0] diff_reg;
    logic                               fa_reg;
    logic                               fb_reg;

    always_comb
    begin
        wide = $signed({1'b0, lane_a.dn}) - $signed({1'b0, lane_b.dn});
        if (wide > dddu_pkg::DIFF_MAX)
            diff_next = dddu_pkg::DIFF_MAX[dddu_pkg::DIFF_W-1:0];
        else if (wide < dddu_pkg::DIFF_MIN)
            diff_next = dddu_pkg::DIFF_MIN[dddu_pkg::DIFF_W-1:0];
        else
            diff_next = wide[dddu_pkg::DIFF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            fa_reg   <= lane_a.ok;
            fb_reg   <= lane_b.ok;
        end
    end

    assign diff         = diff_reg;
    assign first_valid  = fa_reg;
    assign second_valid = fb_reg;

endmodule

`default_nettype wire

FILE: sv/date_difference_in_days_unit.sv
// Pipeline: two lane stages and one merge stage lie between input beat and result beat.
// Throughput: one date pair per cycle; each stage moves when the one after it is
// empty or moving, so a stalled result holds only the stages behind it.
// Reset: rst_n clears the stage valid flags asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// date_difference_in_days_unit
// Gregorian day number difference of two dates, one lane per date.
// ----------------------------------------------------------------------------
`default_nettype none

module date_difference_in_days_unit #(
    parameter int YEAR_MAX = dddu_pkg::YEAR_MAX_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // year_a[13:0] month_a[17:14] day_a[22:18] year_b[36:23] month_b[40:37]
    // day_b[45:41], zero pad [47:46]
    input  wire  [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // day_difference[22:0], zero pad [23]
    output logic [23:0] m_axis_tdata,
    // first_valid[0] second_valid[1]
    output logic [1:0]  m_axis_tuser
);

    dddu_pkg::date_t     date_a;
    dddu_pkg::date_t     date_b;
    dddu_pkg::stage_en_t en;
    dddu_pkg::lane_out_t lane_a;
    dddu_pkg::lane_out_t lane_b;

    logic signed [dddu_pkg::DIFF_W-1:0] diff;
    logic first_valid;
    logic second_valid;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic ready1, ready2, ready3;

    assign date_a.year  = s_axis_tdata[13:0];
    assign date_a.month = s_axis_tdata[17:14];
    assign date_a.day   = s_axis_tdata[22:18];
    assign date_b.year  = s_axis_tdata[36:23];
    assign date_b.month = s_axis_tdata[40:37];
    assign date_b.day   = s_axis_tdata[45:41];

    assign ready3 = !v3_reg || m_axis_tready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign en.s1 = ready1;
    assign en.s2 = ready2;

    assign v1_next = ready1 ? s_axis_tvalid : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;
    assign v3_next = ready3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    dddu_lane #(.YEAR_MAX(YEAR_MAX)) u_lane_a (
        .clk    (clk),
        .en     (en),
        .date   (date_a),
        .result (lane_a)
    );

    dddu_lane #(.YEAR_MAX(YEAR_MAX)) u_lane_b (
        .clk    (clk),
        .en     (en),
        .date   (date_b),
        .result (lane_b)
    );

    dddu_merge u_merge (
        .clk          (clk),
        .en           (ready3),
        .lane_a       (lane_a),
        .lane_b       (lane_b),
        .diff         (diff),
        .first_valid  (first_valid),
        .second_valid (second_valid)
    );

    assign s_axis_tready = ready1;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {1'b0, diff};
    assign m_axis_tuser  = {second_valid, first_valid};

endmodule

`default_nettype wire

FILE: sv/dddu_checker.sv
// ----------------------------------------------------------------------------
// dddu_checker
// Port-level checks of the date difference unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dddu_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser
);

    // result beat waits until taken
    `ASSERT_CLK(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

    `ASSERT_CLK(a_out_stable, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // input side backs up only behind a stalled result
    `ASSERT_CLK(a_stall_cause, clk, rst_n,
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)

    `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !m_axis_tvalid)

endmodule

bind date_difference_in_days_unit dddu_checker u_dddu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
